>>> rtl/core/hrsp_pkg.sv
`default_nettype none
package hrsp_pkg;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_NO_COLON    = 3'd1;
    localparam logic [2:0] ERR_TYPE        = 3'd2;
    localparam logic [2:0] ERR_LENGTH      = 3'd3;
    localparam logic [2:0] ERR_MISSING_END = 3'd4;
    localparam logic [2:0] ERR_DIGIT       = 3'd5;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_END  = 8'h01;

    localparam logic [9:0] HEADER_LEN = 10'd9;
    localparam logic [9:0] POS_MAX    = 10'd1023;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.ok = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h57);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/hex_record_stream_parser.sv
// Intel HEX record parser, one character per transaction.
// Input channel: s_tdata[7:0] is the character (10 ends a line), s_tlast marks end of
// input (the character is then ignored).
// Result channel: m_tuser is the kind (0 data byte, 1 data record accepted, 2 end
// record, 3 error); m_tdata holds address, data byte and error code.
// A transaction produces zero or one result. Each character passes an input register
// and then a result register. Throughput is one character per cycle while the result
// channel does not stall; the only loop is the parser state update.
// The input register keeps accepting while a result waits, as long as that result is
// taken or the input register is empty; when m_tready stays low both registers fill
// and s_tready drops, with nothing lost.
// Data bytes come out as soon as their second digit arrives; a data record is
// reported as accepted or as a length error at its newline. Checksum characters are
// counted but not checked. After any error the block gives no further results until
// reset; after an end record it gives no further results either.
// Synchronous reset clears all parser state and the valid flags of both registers.
`default_nettype none
module hex_record_stream_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // byte_address, data_byte, error_code, zero fill
    output logic [1:0]       m_tuser    // out_kind
);
    import hrsp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_ch_reg;
    logic        in_eoi_reg;

    logic [9:0]  line_pos_reg, line_pos_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] rec_addr_reg, rec_addr_next;
    logic [3:0]  high_nib_reg, high_nib_next;
    logic        end_seen_reg, end_seen_next;
    logic        halted_reg, halted_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [15:0] out_addr_reg, out_addr_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [2:0]  out_err_reg, out_err_next;

    logic        advance;
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [15:0] res_addr;
    logic [7:0]  res_byte;
    logic [2:0]  res_err;
    hex_digit_t  digit;
    logic [9:0]  p;
    logic [9:0]  data_end;
    logic [9:0]  line_len;
    logic [9:0]  off;
    logic [7:0]  kind_val;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign p        = line_pos_reg;
    assign digit    = hex_decode(in_ch_reg);
    assign data_end = HEADER_LEN + {1'b0, byte_count_reg, 1'b0};
    assign line_len = data_end + 10'd2;
    assign off      = p - HEADER_LEN;
    assign kind_val = {high_nib_reg, digit.value};

    always_comb begin
        res_valid       = 1'b0;
        res_kind        = KIND_DATA;
        res_addr        = 16'd0;
        res_byte        = 8'd0;
        res_err         = ERR_NONE;
        line_pos_next   = line_pos_reg;
        byte_count_next = byte_count_reg;
        rec_addr_next   = rec_addr_reg;
        high_nib_next   = high_nib_reg;
        end_seen_next   = end_seen_reg;
        halted_next     = halted_reg;
        if (halted_reg || end_seen_reg) begin
            res_valid = 1'b0;
        end else if (in_eoi_reg) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_err   = ERR_MISSING_END;
        end else if (in_ch_reg == CH_NEWLINE) begin
            res_valid = 1'b1;
            if (p == 10'd0) begin
                res_kind = KIND_ERROR;
                res_err  = ERR_NO_COLON;
            end else if (p < HEADER_LEN || p != line_len) begin
                res_kind = KIND_ERROR;
                res_err  = ERR_LENGTH;
            end else begin
                res_kind      = KIND_ACCEPT;
                res_addr      = rec_addr_reg;
                line_pos_next = 10'd0;
            end
        end else begin
            line_pos_next = (p < POS_MAX) ? p + 10'd1 : POS_MAX;
            if (p == 10'd0) begin
                if (in_ch_reg != CH_COLON) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_err   = ERR_NO_COLON;
                end
            end else if (p < HEADER_LEN) begin
                if (!digit.ok) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_err   = ERR_DIGIT;
                end else if (p == 10'd1 || p == 10'd7) begin
                    high_nib_next = digit.value;
                end else if (p == 10'd2) begin
                    byte_count_next = kind_val;
                end else if (p <= 10'd6) begin
                    rec_addr_next = {rec_addr_reg[11:0], digit.value};
                end else if (kind_val == TYPE_END) begin
                    end_seen_next = 1'b1;
                    res_valid     = 1'b1;
                    res_kind      = KIND_END;
                    res_addr      = rec_addr_reg;
                end else if (kind_val != TYPE_DATA) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_err   = ERR_TYPE;
                end
            end else if (p < data_end) begin
                if (!digit.ok) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_err   = ERR_DIGIT;
                end else if (!off[0]) begin
                    high_nib_next = digit.value;
                end else begin
                    res_valid = 1'b1;
                    res_kind  = KIND_DATA;
                    res_addr  = rec_addr_reg + {7'd0, off[9:1]};
                    res_byte  = {high_nib_reg, digit.value};
                end
            end
        end
        if (res_valid && res_kind == KIND_ERROR) begin
            halted_next = 1'b1;
        end
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_byte_next  = out_byte_reg;
        out_err_next   = out_err_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = res_valid;
            out_kind_next  = res_kind;
            out_addr_next  = res_addr;
            out_byte_next  = res_byte;
            out_err_next   = res_err;
            in_valid_next  = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            line_pos_reg   <= 10'd0;
            byte_count_reg <= 8'd0;
            rec_addr_reg   <= 16'd0;
            high_nib_reg   <= 4'd0;
            end_seen_reg   <= 1'b0;
            halted_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                line_pos_reg   <= line_pos_next;
                byte_count_reg <= byte_count_next;
                rec_addr_reg   <= rec_addr_next;
                high_nib_reg   <= high_nib_next;
                end_seen_reg   <= end_seen_next;
                halted_reg     <= halted_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata;
            in_eoi_reg <= s_tlast;
        end
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
        out_byte_reg <= out_byte_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_err_reg, out_byte_reg, out_addr_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_ERROR) |-> halted_reg)
        else $error("error result without halt");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_END) |-> end_seen_reg)
        else $error("end result without end flag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(halted_reg && end_seen_reg))
        else $error("halted after end record");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("result after halt");

endmodule
`default_nettype wire

>>> tb/sv/tb_hex_record_stream_parser.sv
`timescale 1ns / 1ps

module tb_hex_record_stream_parser;
    import hrsp_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [2:0]  code;
    } parse_result_t;

    typedef enum {
        CLOSE_END_RECORD,
        CLOSE_NO_COLON,
        CLOSE_BAD_TYPE,
        CLOSE_BAD_LENGTH,
        CLOSE_BAD_DIGIT,
        CLOSE_EARLY_EOF
    } close_case_e;

    class hex_parse_scoreboard;
        logic [9:0]    line_pos;
        logic [7:0]    byte_cnt;
        logic [15:0]   rec_addr;
        logic [7:0]    rec_type;
        logic [3:0]    nibble;
        bit            end_seen;
        bit            halted;
        parse_result_t expected_q[$];
        int            mismatches;
        int            checked;

        function new();
            line_pos   = '0;
            byte_cnt   = '0;
            rec_addr   = '0;
            rec_type   = '0;
            nibble     = '0;
            end_seen   = 1'b0;
            halted     = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int digit_of(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
            return -1;
        endfunction

        function void expect_result(logic [1:0] kind, logic [15:0] addr, logic [7:0] value,
                                    logic [2:0] code);
            parse_result_t r;
            r.kind  = kind;
            r.addr  = addr;
            r.value = value;
            r.code  = code;
            expected_q.push_back(r);
        endfunction

        function void raise_error(logic [2:0] code);
            halted = 1'b1;
            expect_result(KIND_ERROR, '0, '0, code);
        endfunction

        // one accepted input transaction
        function void note_input(logic [7:0] c, logic eoi);
            logic [9:0] p;
            logic [9:0] off;
            int         d;
            p = line_pos;
            if (halted || end_seen) return;
            if (eoi) begin
                raise_error(ERR_MISSING_END);
                return;
            end
            if (c == CH_NEWLINE) begin
                if (p == 10'd0) begin
                    raise_error(ERR_NO_COLON);
                end else if (p < HEADER_LEN || int'(p) != 11 + 2 * int'(byte_cnt)) begin
                    raise_error(ERR_LENGTH);
                end else begin
                    line_pos = '0;
                    expect_result(KIND_ACCEPT, rec_addr, '0, ERR_NONE);
                end
                return;
            end
            line_pos = (p < POS_MAX) ? p + 10'd1 : POS_MAX;
            if (p == 10'd0) begin
                if (c != CH_COLON) raise_error(ERR_NO_COLON);
                return;
            end
            if (p < HEADER_LEN) begin
                d = digit_of(c);
                if (d < 0) begin
                    raise_error(ERR_DIGIT);
                    return;
                end
                case (p)
                    10'd1, 10'd7: nibble = 4'(d);
                    10'd2: byte_cnt = {nibble, 4'(d)};
                    10'd3, 10'd4, 10'd5, 10'd6: rec_addr = {rec_addr[11:0], 4'(d)};
                    default: begin
                        rec_type = {nibble, 4'(d)};
                        if (rec_type == TYPE_END) begin
                            end_seen = 1'b1;
                            expect_result(KIND_END, rec_addr, '0, ERR_NONE);
                        end else if (rec_type != TYPE_DATA) begin
                            raise_error(ERR_TYPE);
                        end
                    end
                endcase
                return;
            end
            if (int'(p) < 9 + 2 * int'(byte_cnt)) begin
                off = p - HEADER_LEN;
                d = digit_of(c);
                if (d < 0) begin
                    raise_error(ERR_DIGIT);
                end else if (!off[0]) begin
                    nibble = 4'(d);
                end else begin
                    expect_result(KIND_DATA, rec_addr + 16'(off >> 1), {nibble, 4'(d)},
                                  ERR_NONE);
                end
            end
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] word);
            parse_result_t r;
            if (expected_q.size() == 0) begin
                $error("unexpected result: kind %0d, tdata %08h", kind, word);
                mismatches++;
                return;
            end
            r = expected_q.pop_front();
            checked++;
            compare_field("out_kind", 16'(r.kind), 16'(kind));
            compare_field("byte_address", r.addr, word[15:0]);
            compare_field("data_byte", 16'(r.value), 16'(word[23:16]));
            compare_field("error_code", 16'(r.code), 16'(word[26:24]));
            compare_field("zero fill", 16'd0, 16'(word[31:27]));
        endfunction
    endclass

    localparam int STALL_LIMIT = 5000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          chars_sent   = 0;
    int          lines_sent   = 0;
    int          stall_cycles = 0;
    int          length_form  = 0;
    int          body_len     = 1450;
    close_case_e close_case   = CLOSE_END_RECORD;
    hex_parse_scoreboard sb;

    always #1 aclk = ~aclk;

    hex_record_stream_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // result monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_ascii(logic [3:0] v, bit lower);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = any_char(); while (sb.digit_of(c) >= 0);
        return c;
    endfunction

    function automatic logic [3:0] any_nibble();
        return 4'($urandom_range(15));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(c, eoi);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    task automatic send_hex(input logic [15:0] v, input int ndig);
        for (int i = ndig - 1; i >= 0; i--) begin
            send_char(hex_ascii(v[4*i +: 4], $urandom_range(1)), 1'b0);
        end
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_char(hex_ascii(any_nibble(), $urandom_range(1)), 1'b0);
    endtask

    task automatic send_header(input logic [7:0] cnt, input logic [15:0] addr,
                               input logic [7:0] rtype);
        send_char(CH_COLON, 1'b0);
        send_hex(16'(cnt), 2);
        send_hex(addr, 4);
        send_hex(16'(rtype), 2);
    endtask

    // data record with cs_len checksum characters; cs_len 2 is well formed
    task automatic send_data_line(input int cnt, input logic [15:0] addr, input int cs_len);
        send_header(8'(cnt), addr, TYPE_DATA);
        send_digits(2 * cnt);
        repeat (cs_len) send_char(any_char(), 1'b0);
        send_char(CH_NEWLINE, 1'b0);
        lines_sent++;
    endtask

    task automatic random_lines(input int upto);
        int          cnt;
        logic [15:0] addr;
        while (chars_sent < upto) begin
            cnt  = ($urandom_range(3) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
            addr = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(20))
                                            : 16'($urandom_range(16'hFFFF));
            send_data_line(cnt, addr, 2);
        end
    endtask

    // one way of ending the stream; every path halts the parser or ends the file
    task automatic close_stream();
        int cnt;
        case (close_case)
            CLOSE_END_RECORD: begin
                send_header(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), TYPE_END);
                send_char(any_char(), 1'b0);
                send_char(any_char(), 1'b0);
                send_char(CH_NEWLINE, 1'b0);
            end
            CLOSE_NO_COLON: begin
                if ($urandom_range(1)) begin
                    send_char(CH_NEWLINE, 1'b0);
                end else begin
                    send_char(8'h3B + 8'($urandom_range(8'hC4)), 1'b0);
                end
            end
            CLOSE_BAD_TYPE: begin
                send_header(8'($urandom_range(8)), 16'($urandom_range(16'hFFFF)),
                            8'($urandom_range(2, 255)));
                send_digits(4);
                send_char(CH_NEWLINE, 1'b0);
            end
            CLOSE_BAD_LENGTH: begin
                cnt = $urandom_range(0, 6);
                case (length_form)
                    0: begin
                        send_char(CH_COLON, 1'b0);
                        send_digits($urandom_range(0, 7));
                        send_char(CH_NEWLINE, 1'b0);
                    end
                    1: send_data_line(cnt, 16'($urandom_range(16'hFFFF)),
                                      $urandom_range(1) ? 1 : 3);
                    default: send_data_line(cnt, 16'($urandom_range(16'hFFFF)), 1100);
                endcase
            end
            CLOSE_BAD_DIGIT: begin
                if ($urandom_range(1)) begin
                    send_char(CH_COLON, 1'b0);
                    send_digits($urandom_range(0, 7));
                end else begin
                    cnt = $urandom_range(1, 8);
                    send_header(8'(cnt), 16'($urandom_range(16'hFFFF)), TYPE_DATA);
                    send_digits($urandom_range(0, 2 * cnt - 1));
                end
                send_char(non_hex_char(), 1'b0);
            end
            default: begin
                if ($urandom_range(1)) begin
                    send_char(CH_COLON, 1'b0);
                    send_digits($urandom_range(0, 6));
                end
                send_char(8'($urandom_range(255)), 1'b1);
            end
        endcase
        // the parser ignores everything from here on
        repeat (8) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        sb = new();
        close_case  = close_case_e'($urandom_range(5));
        length_form = $urandom_range(2);
        // the overlong closing line takes most of the character budget
        if (close_case == CLOSE_BAD_LENGTH && length_form == 2) body_len = 330;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 37;
        snk_idle_pct = 86;
        // empty record at the top address, then two bytes wrapping past it
        send_text(":00FFFF00");
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(CH_NEWLINE, 1'b0);
        send_text(":02fFfF00a5B709\n");
        lines_sent += 2;
        random_lines(body_len / 3);

        src_idle_pct = 86;
        snk_idle_pct = 37;
        if (body_len > 1000) send_data_line(255, 16'($urandom_range(16'hFFFF)), 2);
        random_lines(body_len * 3 / 4);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_lines(body_len);
        close_stream();
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d characters in %0d data records, checked %0d results",
                 chars_sent, lines_sent, sb.checked);
        $display("stream closed by %s", close_case.name());
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
